// ===== rtl/u8u16_pkg.sv =====
// ---------------------------------------------------------------------------
// u8u16_pkg
// Shared word types and byte-class constants for the UTF-8 to UTF-16 decoder.
// ---------------------------------------------------------------------------
package u8u16_pkg;

  // Input word: one UTF-8 byte plus the string-end flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_word_t;

  // Output word: one 16-bit code unit plus flags.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        string_done;
  } unit_word_t;

  // Decode result handed from the decode stage to the output register.
  typedef struct packed {
    logic       emit;
    unit_word_t word;
  } dec_res_t;

  localparam logic [7:0] ASCII_MAX     = 8'h7F;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;
  localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_CODE    = 8'hE0;
  localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
  localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

  localparam logic [1:0] DUE_NONE = 2'd0;
  localparam logic [1:0] DUE_ONE  = 2'd1;
  localparam logic [1:0] DUE_TWO  = 2'd2;

endpackage

// ===== rtl/u8u16_decode.sv =====
// ---------------------------------------------------------------------------
// u8u16_decode
// Sequence state and single-pass byte decode for the UTF-8 to UTF-16 decoder.
// ---------------------------------------------------------------------------
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  byte_word_t item,
  output dec_res_t   res
);

  logic [1:0]  bytes_due;
  logic [9:0]  partial_bits;
  logic [1:0]  bytes_due_next;
  logic [9:0]  partial_bits_next;
  logic [15:0] acc;
  logic        have;
  logic [15:0] unit;
  logic [7:0]  b;

  assign b   = item.data_byte;
  assign acc = {partial_bits, b[5:0] & CONT_PAYLOAD[5:0]};

  always_comb begin
    bytes_due_next    = bytes_due;
    partial_bits_next = partial_bits;
    have              = 1'b0;
    unit              = 16'h0000;

    if (bytes_due != DUE_NONE) begin
      bytes_due_next = bytes_due - 2'd1;
      if (bytes_due == DUE_ONE) begin
        unit              = acc;
        have              = 1'b1;
        partial_bits_next = 10'h000;
      end else begin
        partial_bits_next = acc[9:0];
      end
    end else if (b <= ASCII_MAX) begin
      unit = {8'h00, b};
      have = 1'b1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      partial_bits_next = {2'b00, b & LEAD2_PAYLOAD};
      bytes_due_next    = DUE_ONE;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      partial_bits_next = {2'b00, b & LEAD3_PAYLOAD};
      bytes_due_next    = DUE_TWO;
    end
    // other lead bytes fall through and are dropped

    // end of string discards any open sequence
    if (item.end_of_string) begin
      bytes_due_next    = DUE_NONE;
      partial_bits_next = 10'h000;
    end

    res.emit                  = have | item.end_of_string;
    res.word.code_unit        = have ? unit : 16'h0000;
    res.word.has_unit         = have;
    res.word.string_done      = item.end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_due    <= DUE_NONE;
      partial_bits <= 10'h000;
    end else if (advance) begin
      bytes_due    <= bytes_due_next;
      partial_bits <= partial_bits_next;
    end
  end

endmodule

// ===== rtl/u8u16_out_reg.sv =====
// ---------------------------------------------------------------------------
// u8u16_out_reg
// Result register for the output channel; holds a word until it is taken.
// ---------------------------------------------------------------------------
module u8u16_out_reg
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  unit_word_t din,
  output logic       can_take,
  output logic       valid,
  input  logic       ready,
  output unit_word_t data
);

  // free now, or emptied at this edge by the receiver
  assign can_take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_decoder_top.sv =====
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// Streaming UTF-8 to UTF-16 decoder for the one-, two- and three-byte forms.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel byte_valid/byte_ready/byte_data carries one word per
//   UTF-8 byte; end_of_string marks the last byte of a string.
//   Output channel unit_valid/unit_ready/unit_data carries one word per
//   decoded code unit; the word for a string's last byte has string_done set.
//   Bytes that only open or extend a sequence, and do not end a string, produce no output word.
// Timing:
//   One byte per cycle sustained while unit_ready holds high. An accepted
//   byte is captured in the input register, decoded out of it
//   combinationally, and its word, if any, is then loaded into the result
//   register. The only feedback loop is the 2-bit due count and 10-bit
//   partial payload, which update as each byte is decoded, so there is no
//   rate limit beyond the handshakes.
// Reset (rst, synchronous, active high):
//   Empties both registers and clears any open sequence.
// Stall:
//   When unit_ready is low with a word waiting, the byte in the input
//   register holds, whether or not it makes a word, and byte_ready drops
//   once the input register is occupied. Nothing is lost.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder_top
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_word_t byte_data,
  output logic       unit_valid,
  input  logic       unit_ready,
  output unit_word_t unit_data
);

  logic       in_full;
  byte_word_t in_item;
  logic       out_take;
  logic       advance;
  dec_res_t   res;

  // decode stage moves when it holds a byte and the result register is free;
  // a byte that yields no word also needs the free slot, keeping control simple
  assign advance    = in_full && out_take;
  assign byte_ready = !in_full || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_item <= byte_data;
    end
  end

  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .res     (res)
  );

  u8u16_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res.emit),
    .din      (res.word),
    .can_take (out_take),
    .valid    (unit_valid),
    .ready    (unit_ready),
    .data     (unit_data)
  );

  // every delivered word carries a unit or closes a string
  a_no_empty_word: assert property (@(posedge clk) disable iff (rst)
    unit_valid |-> (unit_data.has_unit || unit_data.string_done))
    else $error("output word with neither unit nor string end");

  // a word without a unit has a zero code unit
  a_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && !unit_data.has_unit) |-> (unit_data.code_unit == 16'h0000))
    else $error("code unit nonzero without has_unit");

  // input side never blocks while the decode stage can drain
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!in_full || !unit_valid) |-> byte_ready)
    else $error("byte_ready low with room available");

  // a held byte with a free output register is decoded at this edge
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (in_full && !unit_valid && !byte_valid) |=> !in_full)
    else $error("input register did not drain");

endmodule
